FILE: rtl/core/fpe_pkg.sv
// shared types, constants and helpers for the frustum plane extractor
package fpe_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 32;
    localparam int TERM_W        = ELEM_W + 1;
    localparam int MAG_W         = TERM_W;
    localparam int SQ_W          = 2 * MAG_W;
    localparam int SUM_W         = 68;
    localparam int ROOT_W        = SUM_W / 2;
    localparam int SREM_W        = ROOT_W + 3;
    localparam int DREM_W        = ROOT_W;
    localparam int QUO_W         = 32;
    localparam int SQ_STEPS      = 4;
    localparam int SQRT_STEPS    = ROOT_W;
    localparam int DIV_STEPS     = QUO_W;
    localparam int CNT_W         = 6;
    localparam int NUM_PLANES    = 6;

    localparam logic [2:0] PLANE_LEFT   = 3'd0;
    localparam logic [2:0] PLANE_RIGHT  = 3'd1;
    localparam logic [2:0] PLANE_TOP    = 3'd2;
    localparam logic [2:0] PLANE_BOTTOM = 3'd3;
    localparam logic [2:0] PLANE_NEAR   = 3'd4;
    localparam logic [2:0] PLANE_FAR    = 3'd5;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_c1;
        logic signed [ELEM_W-1:0] elem_c2;
        logic signed [ELEM_W-1:0] elem_c3;
        logic signed [ELEM_W-1:0] elem_c4;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]               plane_index;
        logic signed [ELEM_W-1:0] normal_x;
        logic signed [ELEM_W-1:0] normal_y;
        logic signed [ELEM_W-1:0] normal_z;
        logic signed [ELEM_W-1:0] distance;
        logic                     degenerate;
        logic                     last_plane;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM,
        ST_SQ,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT_LOAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       load_row;
        logic       latch_terms;
        logic       sq_step;
        logic [1:0] sq_sel;
        logic       root_init;
        logic       root_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
        logic       next_plane;
    } cmd_t;

    typedef struct packed {
        logic row_last;
        logic plane_last;
    } stat_t;

    function automatic logic signed [TERM_W-1:0] plane_term(
        input in_beat_t   row,
        input logic [2:0] kind
    );
        logic signed [TERM_W-1:0] c1, c2, c3, c4, res;
        c1 = TERM_W'(row.elem_c1);
        c2 = TERM_W'(row.elem_c2);
        c3 = TERM_W'(row.elem_c3);
        c4 = TERM_W'(row.elem_c4);
        unique case (kind)
            PLANE_LEFT:   res = c4 + c1;
            PLANE_RIGHT:  res = c4 - c1;
            PLANE_TOP:    res = c4 - c2;
            PLANE_BOTTOM: res = c4 + c2;
            PLANE_NEAR:   res = c3;
            default:      res = c4 - c3;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/fpe_ctrl.sv
// sequencer for loading rows and normalizing the six planes
module fpe_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  fpe_pkg::stat_t stat,
    output fpe_pkg::cmd_t  cmd
);

    fpe_pkg::state_t state_reg, state_next;
    logic [fpe_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpe_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        unique case (state_reg)
            fpe_pkg::ST_IDLE: begin
                if (s_valid && stat.row_last) begin
                    state_next = fpe_pkg::ST_TERM;
                end
            end
            fpe_pkg::ST_TERM: begin
                state_next = fpe_pkg::ST_SQ;
                cnt_next   = '0;
            end
            fpe_pkg::ST_SQ: begin
                if (cnt_reg == fpe_pkg::CNT_W'(fpe_pkg::SQ_STEPS - 1)) begin
                    state_next = fpe_pkg::ST_ROOT_INIT;
                end
            end
            fpe_pkg::ST_ROOT_INIT: begin
                state_next = fpe_pkg::ST_ROOT;
                cnt_next   = '0;
            end
            fpe_pkg::ST_ROOT: begin
                if (cnt_reg == fpe_pkg::CNT_W'(fpe_pkg::SQRT_STEPS - 1)) begin
                    state_next = fpe_pkg::ST_DIV_INIT;
                end
            end
            fpe_pkg::ST_DIV_INIT: begin
                state_next = fpe_pkg::ST_DIV;
                cnt_next   = '0;
            end
            fpe_pkg::ST_DIV: begin
                if (cnt_reg == fpe_pkg::CNT_W'(fpe_pkg::DIV_STEPS - 1)) begin
                    state_next = fpe_pkg::ST_OUT_LOAD;
                end
            end
            fpe_pkg::ST_OUT_LOAD: begin
                state_next = fpe_pkg::ST_OUT;
            end
            fpe_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = stat.plane_last ? fpe_pkg::ST_IDLE : fpe_pkg::ST_TERM;
                end
            end
            default: begin
                state_next = fpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.sq_sel      = cnt_reg[1:0];
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        unique case (state_reg)
            fpe_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_row = s_valid;
            end
            fpe_pkg::ST_TERM:      cmd.latch_terms = 1'b1;
            fpe_pkg::ST_SQ:        cmd.sq_step     = 1'b1;
            fpe_pkg::ST_ROOT_INIT: cmd.root_init   = 1'b1;
            fpe_pkg::ST_ROOT:      cmd.root_step   = 1'b1;
            fpe_pkg::ST_DIV_INIT:  cmd.div_init    = 1'b1;
            fpe_pkg::ST_DIV:       cmd.div_step    = 1'b1;
            fpe_pkg::ST_OUT_LOAD:  cmd.out_load    = 1'b1;
            fpe_pkg::ST_OUT: begin
                m_valid        = 1'b1;
                cmd.next_plane = m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/fpe_datapath.sv
// matrix rows, squarer, square root and divider lanes, result register
module fpe_datapath #(
    parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fpe_pkg::in_beat_t  s_data,
    input  fpe_pkg::cmd_t      cmd,
    output fpe_pkg::stat_t     stat,
    output fpe_pkg::out_beat_t m_data
);

    localparam int NUM_W = fpe_pkg::TERM_W + FRAC_BITS + 1;
    localparam int HI_W  = NUM_W - fpe_pkg::QUO_W;

    fpe_pkg::in_beat_t rows_reg [4];
    logic [1:0] row_cnt_reg;
    logic [2:0] plane_reg;

    logic signed [fpe_pkg::TERM_W-1:0] term_reg [4];
    logic [fpe_pkg::SQ_W-1:0]  prod_reg;
    logic [fpe_pkg::SUM_W-1:0] acc_reg;

    logic [fpe_pkg::SUM_W-1:0]  s_reg;
    logic [fpe_pkg::SREM_W-1:0] srem_reg;
    logic [fpe_pkg::ROOT_W-1:0] root_reg;
    logic                       degen_reg;

    logic [fpe_pkg::DREM_W-1:0] drem_reg [4];
    logic [fpe_pkg::QUO_W-1:0]  low_reg  [4];
    logic [fpe_pkg::QUO_W-1:0]  quo_reg  [4];
    logic                       sat_reg  [4];
    logic                       neg_reg  [4];

    fpe_pkg::out_beat_t out_reg;

    function automatic logic [fpe_pkg::MAG_W-1:0] mag_of(
        input logic signed [fpe_pkg::TERM_W-1:0] t
    );
        return t[fpe_pkg::TERM_W-1] ? fpe_pkg::MAG_W'(-t) : fpe_pkg::MAG_W'(t);
    endfunction

    function automatic logic [fpe_pkg::ELEM_W-1:0] finish(
        input logic                      neg,
        input logic                      sat,
        input logic [fpe_pkg::QUO_W-1:0] q
    );
        logic [fpe_pkg::ELEM_W-1:0] res;
        if (neg) begin
            if (sat || q > 32'h8000_0000) begin
                res = 32'h8000_0000;
            end else begin
                res = -q;
            end
        end else begin
            if (sat || q[fpe_pkg::QUO_W-1]) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = q;
            end
        end
        return res;
    endfunction

    logic [fpe_pkg::MAG_W-1:0]  sq_in;
    logic [fpe_pkg::SREM_W-1:0] srem_sh, trial;
    logic [NUM_W-1:0]           num   [4];
    logic [fpe_pkg::DREM_W:0]   drem_sh [4];

    assign stat.row_last   = (row_cnt_reg == 2'd3);
    assign stat.plane_last = (plane_reg == fpe_pkg::PLANE_FAR);
    assign m_data          = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            plane_reg   <= fpe_pkg::PLANE_LEFT;
        end else begin
            if (cmd.load_row) begin
                row_cnt_reg <= row_cnt_reg + 1'b1;
            end
            if (cmd.next_plane) begin
                plane_reg <= stat.plane_last ? fpe_pkg::PLANE_LEFT : plane_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_row) begin
            rows_reg[row_cnt_reg] <= s_data;
        end
    end

    // per-plane terms and sum of squares
    always_comb begin
        sq_in = (cmd.sq_sel == 2'd3) ? '0 : mag_of(term_reg[cmd.sq_sel]);
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_terms) begin
            for (int i = 0; i < 4; i++) begin
                term_reg[i] <= fpe_pkg::plane_term(rows_reg[i], plane_reg);
            end
            prod_reg <= '0;
            acc_reg  <= '0;
        end else if (cmd.sq_step) begin
            prod_reg <= sq_in * sq_in;
            acc_reg  <= acc_reg + fpe_pkg::SUM_W'(prod_reg);
        end
    end

    // square root, two bits per step
    always_comb begin
        srem_sh = {srem_reg[fpe_pkg::SREM_W-3:0], s_reg[fpe_pkg::SUM_W-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (cmd.root_init) begin
            s_reg     <= acc_reg;
            srem_reg  <= '0;
            root_reg  <= '0;
            degen_reg <= (acc_reg == '0);
        end else if (cmd.root_step) begin
            s_reg <= {s_reg[fpe_pkg::SUM_W-3:0], 2'b00};
            if (srem_sh >= trial) begin
                srem_reg <= srem_sh - trial;
                root_reg <= {root_reg[fpe_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[fpe_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // four divider lanes, one quotient bit per step
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            num[i] = NUM_W'({mag_of(term_reg[i]), {FRAC_BITS{1'b0}}})
                   + NUM_W'(root_reg[fpe_pkg::ROOT_W-1:1]);
            drem_sh[i] = {drem_reg[i], low_reg[i][fpe_pkg::QUO_W-1]};
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            if (cmd.div_init) begin
                drem_reg[i] <= fpe_pkg::DREM_W'(num[i][NUM_W-1 -: HI_W]);
                low_reg[i]  <= num[i][fpe_pkg::QUO_W-1:0];
                quo_reg[i]  <= '0;
                sat_reg[i]  <= (fpe_pkg::ROOT_W'(num[i][NUM_W-1 -: HI_W]) >= root_reg);
                neg_reg[i]  <= term_reg[i][fpe_pkg::TERM_W-1];
            end else if (cmd.div_step) begin
                low_reg[i] <= {low_reg[i][fpe_pkg::QUO_W-2:0], 1'b0};
                if (drem_sh[i] >= {1'b0, root_reg}) begin
                    drem_reg[i] <= fpe_pkg::DREM_W'(drem_sh[i] - {1'b0, root_reg});
                    quo_reg[i]  <= {quo_reg[i][fpe_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    drem_reg[i] <= fpe_pkg::DREM_W'(drem_sh[i]);
                    quo_reg[i]  <= {quo_reg[i][fpe_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.plane_index <= plane_reg;
            out_reg.degenerate  <= degen_reg;
            out_reg.last_plane  <= stat.plane_last;
            if (degen_reg) begin
                out_reg.normal_x <= '0;
                out_reg.normal_y <= '0;
                out_reg.normal_z <= '0;
                out_reg.distance <= '0;
            end else begin
                out_reg.normal_x <= finish(neg_reg[0], sat_reg[0], quo_reg[0]);
                out_reg.normal_y <= finish(neg_reg[1], sat_reg[1], quo_reg[1]);
                out_reg.normal_z <= finish(neg_reg[2], sat_reg[2], quo_reg[2]);
                out_reg.distance <= finish(neg_reg[3], sat_reg[3], quo_reg[3]);
            end
        end
    end

endmodule

FILE: rtl/core/frustum_plane_extract_top.sv
// top level of the frustum plane extractor
//
// s_ channel: one beat per matrix row, rows 1 to 4 in order, four signed
// fixed-point elements each. Rows one to three are simply stored.
// The beat with the fourth row starts normalization of six planes, sent on
// the m_ channel as six beats: left, right, top, bottom, near, far, with
// last_plane set on the far plane.
// Each plane is worked in order: terms latched, sum of squares on one
// shared squarer, two-bit-per-step square root, then four parallel
// one-bit-per-step divider lanes, with load states between the steps.
// A matrix thus costs 4 row beats plus the work on its six planes.
// s_ready is high only while no planes are in flight.
// A stalled m_ channel holds the current plane and halts the sequencer.
// Reset clears the row counter, plane counter and sequencer; stored rows
// need no clearing since each run rewrites all four.
module frustum_plane_extract_top #(
    parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fpe_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fpe_pkg::out_beat_t m_data
);

    fpe_pkg::cmd_t  cmd;
    fpe_pkg::stat_t stat;

    fpe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fpe_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a plane is pending");

    a_last_is_far: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_plane == (m_data.plane_index == fpe_pkg::PLANE_FAR)))
        else $error("last_plane flag mismatch");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.degenerate) |->
        (m_data.normal_x == '0 && m_data.normal_y == '0 &&
         m_data.normal_z == '0 && m_data.distance == '0))
        else $error("degenerate plane not zeroed");

    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_plane) |=> s_ready)
        else $error("not ready after final plane");

endmodule

FILE: tb/frustum_plane_extract_top_tb.sv
// testbench for the frustum plane extractor: directed and random matrix rows, planes checked
`timescale 1ns / 1ps

module frustum_plane_extract_top_tb;

    localparam int FB = fpe_pkg::FRAC_BITS_DEF;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    fpe_pkg::in_beat_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    fpe_pkg::out_beat_t m_data;

    frustum_plane_extract_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    typedef struct {
        fpe_pkg::in_beat_t  row;
        logic               has_exp;
        fpe_pkg::out_beat_t exp [6];
    } stim_row_t;

    fpe_pkg::in_beat_t  rows_q[$];
    fpe_pkg::out_beat_t planes_exp_q[$];
    fpe_pkg::out_beat_t planes_fixed_q[$];
    logic               fixed_mark_q[$];
    fpe_pkg::in_beat_t  mat[4];
    int        row_cnt = 0;
    int        mismatches = 0;
    bit        feed_done = 0;
    bit        quiet = 0;
    bit        hold_off = 0;

    function automatic logic [67:0] isqrt68(logic [67:0] s);
        logic [67:0] r, t;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t = r | (68'd1 << b);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] norm_scale(logic signed [32:0] v,
                                                     logic [67:0] mag);
        logic [67:0] a, q;
        a = v < 0 ? 68'(-v) : 68'(v);
        q = ((a << FB) + (mag >> 1)) / mag;
        if (v < 0) begin
            if (q > 68'h80000000) q = 68'h80000000;
            return 32'(-q);
        end
        if (q > 68'h7fffffff) q = 68'h7fffffff;
        return 32'(q);
    endfunction

    function automatic logic signed [32:0] col_term(fpe_pkg::in_beat_t r, int k);
        logic signed [32:0] c1, c2, c3, c4;
        c1 = r.elem_c1; c2 = r.elem_c2; c3 = r.elem_c3; c4 = r.elem_c4;
        case (k)
            fpe_pkg::PLANE_LEFT:   return c4 + c1;
            fpe_pkg::PLANE_RIGHT:  return c4 - c1;
            fpe_pkg::PLANE_TOP:    return c4 - c2;
            fpe_pkg::PLANE_BOTTOM: return c4 + c2;
            fpe_pkg::PLANE_NEAR:   return c3;
            default:               return c4 - c3;
        endcase
    endfunction

    task automatic predict_planes(fpe_pkg::in_beat_t r);
        logic signed [32:0] n[3];
        logic signed [32:0] d;
        logic [67:0] s, a, mag;
        fpe_pkg::out_beat_t o;
        mat[row_cnt] = r;
        if (row_cnt != 3) begin
            row_cnt++;
            return;
        end
        row_cnt = 0;
        for (int p = 0; p < fpe_pkg::NUM_PLANES; p++) begin
            s = '0;
            for (int i = 0; i < 3; i++) begin
                n[i] = col_term(mat[i], p);
                a = n[i] < 0 ? 68'(-n[i]) : 68'(n[i]);
                s += a * a;
            end
            d = col_term(mat[3], p);
            o = '0;
            o.plane_index = 3'(p);
            o.last_plane = (p == fpe_pkg::NUM_PLANES - 1);
            if (s == 0) begin
                o.degenerate = 1'b1;
            end else begin
                mag = isqrt68(s);
                o.normal_x = norm_scale(n[0], mag);
                o.normal_y = norm_scale(n[1], mag);
                o.normal_z = norm_scale(n[2], mag);
                o.distance = norm_scale(d, mag);
            end
            planes_exp_q.push_back(o);
        end
    endtask

    function automatic fpe_pkg::in_beat_t mk(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] c, logic [31:0] e);
        fpe_pkg::in_beat_t r;
        r.elem_c1 = a; r.elem_c2 = b; r.elem_c3 = c; r.elem_c4 = e;
        return r;
    endfunction

    function automatic fpe_pkg::in_beat_t rnd_row(int style);
        fpe_pkg::in_beat_t r;
        r = mk($urandom, $urandom, $urandom, $urandom);
        if (style == 1) begin
            r.elem_c1 = $signed(32'($urandom_range(0, 262143))) - 131072;
            r.elem_c2 = $signed(32'($urandom_range(0, 262143))) - 131072;
            r.elem_c3 = $signed(32'($urandom_range(0, 262143))) - 131072;
            r.elem_c4 = $signed(32'($urandom_range(0, 262143))) - 131072;
        end else if (style == 2) begin
            r.elem_c1 = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            r.elem_c3 = $urandom_range(0, 1) ? 32'h0 : 32'h80000000;
        end
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_row(fpe_pkg::in_beat_t r, bit has_exp,
                            fpe_pkg::out_beat_t e [6]);
        int n0;
        while (!quiet && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        n0 = planes_exp_q.size();
        predict_planes(r);
        for (int i = n0; i < planes_exp_q.size(); i++) begin
            fixed_mark_q.push_back(has_exp);
            planes_fixed_q.push_back(has_exp ? e[i - n0] : '0);
        end
        @(negedge aclk);
    endtask

    stim_row_t dir_tab[$];

    task automatic add_row(fpe_pkg::in_beat_t r);
        stim_row_t t;
        t.row = r; t.has_exp = 1'b0;
        for (int p = 0; p < 6; p++) t.exp[p] = '0;
        dir_tab.push_back(t);
    endtask

    initial begin
        fpe_pkg::out_beat_t e;
        stim_row_t t;
        // all-zero matrix: every plane degenerate
        for (int i = 0; i < 4; i++) add_row(mk(0, 0, 0, 0));
        for (int p = 0; p < 6; p++) begin
            e = '0;
            e.plane_index = 3'(p);
            e.degenerate = 1'b1;
            e.last_plane = (p == 5);
            dir_tab[3].exp[p] = e;
        end
        dir_tab[3].has_exp = 1'b1;
        // identity
        add_row(mk(32'h10000, 0, 0, 0));
        add_row(mk(0, 32'h10000, 0, 0));
        add_row(mk(0, 0, 32'h10000, 0));
        add_row(mk(0, 0, 0, 32'h10000));
        // extremes, saturated distance
        add_row(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
        add_row(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
        add_row(mk(32'hffffffff, 32'h1, 32'h80000000, 32'h7fffffff));
        add_row(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        add_row(mk(0, 0, 0, 1));
        add_row(mk(0, 0, 0, 1));
        add_row(mk(0, 0, 1, 0));
        add_row(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
        add_row(mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
        add_row(mk(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa));
        add_row(mk(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555));
        add_row(mk(32'h1, 32'h0, 32'h0, 32'h7fffffff));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < dir_tab.size(); i++) begin
            t = dir_tab[i];
            send_row(t.row, t.has_exp, t.exp);
        end
        for (int i = 0; i < 296; i++) begin
            if (i == 100) quiet = 1;
            if (i == 160) quiet = 0;
            if (i == 200) hold_off = 1;
            send_row(rnd_row((i / 4) % 3), 1'b0, t.exp);
        end
        s_valid <= 1'b0;
        feed_done = 1;
    end

    initial begin
        int stall_cnt;
        stall_cnt = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                stall_cnt++;
                if (stall_cnt >= 2000) hold_off = 0;
            end else begin
                m_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 10);
            end
        end
    end

    always @(posedge aclk) begin
        fpe_pkg::out_beat_t e;
        fpe_pkg::out_beat_t f;
        logic               mark;
        if (aresetn && m_valid && m_ready) begin
            if (planes_exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected plane %p", m_data);
            end else begin
                e = planes_exp_q.pop_front();
                f = planes_fixed_q.pop_front();
                mark = fixed_mark_q.pop_front();
                if (m_data !== e || (mark && m_data !== f)) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("plane mismatch: expected %p, got %p",
                                 (mark ? f : e), m_data);
                end
            end
        end
    end

    initial begin
        wait (feed_done);
        while (planes_exp_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0)
            $display("[frustum_plane_extract_top] OK");
        else
            $display("[frustum_plane_extract_top] ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("[frustum_plane_extract_top] ERROR");
        $finish;
    end

endmodule
